// File: design/mav_pkg.sv
package mav_pkg;

  typedef enum logic [2:0] {
    K_GLOBAL = 3'd0,
    K_ALLOC  = 3'd1,
    K_FREE   = 3'd2,
    K_UAF    = 3'd3,
    K_READ   = 3'd4,
    K_WRITE  = 3'd5,
    K_LEAK   = 3'd6,
    K_NONE   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    EV_OK             = 3'd0,
    EV_DOUBLE_FREE    = 3'd1,
    EV_INVALID_FREE   = 3'd2,
    EV_USE_AFTER_FREE = 3'd3,
    EV_INVALID_READ   = 3'd4,
    EV_INVALID_WRITE  = 3'd5,
    EV_LEAK           = 3'd6,
    EV_TABLE_FULL     = 3'd7
  } ev_t;

  localparam logic [15:0] RED_ZONE_RESET = 16'd128;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [31:0] size_bytes;
    logic [31:0] stack_pointer;
    logic [31:0] stack_base;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] event_address;
    logic [31:0] leak_size;
    logic        last;
  } res_t;

  // queue entry: command plus precomputed stack-window verdict
  typedef struct packed {
    cmd_t cmd;
    logic in_stack;
  } job_t;

endpackage

// File: design/mav_if.sv
interface mav_cmd_if;
  logic valid;
  logic ready;
  mav_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mav_res_if;
  logic valid;
  logic ready;
  mav_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mav_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/mav_ram.sv
module mav_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/mav_front.sv
module mav_front #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       red_zone,
  input  logic              in_valid,
  output logic              in_ready,
  input  mav_pkg::cmd_t     in_cmd,
  output logic              q_valid,
  input  logic              q_ready,
  output mav_pkg::job_t     q_job
);
  import mav_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t fifo [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic push, pop;
  job_t job_in;
  logic [32:0] lo_sum, hi_sum;

  // stack window classification
  always_comb begin
    lo_sum = {1'b0, in_cmd.address} + {17'd0, red_zone};
    hi_sum = {1'b0, in_cmd.address} + {1'b0, in_cmd.size_bytes};
    job_in.cmd = in_cmd;
    job_in.in_stack = ({1'b0, in_cmd.stack_pointer} <= lo_sum) &&
                      (hi_sum <= {1'b0, in_cmd.stack_base});
  end

  assign in_ready = (count != (AW+1)'(DEPTH));
  assign q_valid  = (count != '0);
  assign q_job    = fifo[rptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= job_in;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue overfill");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == (AW+1)'(DEPTH)) && !pop |=> count == (AW+1)'(DEPTH))
    else $error("queue count moved while full");
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> count == '0) else $error("queue not empty after reset");
endmodule

// File: design/mav_back.sv
module mav_back #(
  parameter int HEAP_ENTRIES   = 64,
  parameter int GLOBAL_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  mav_pkg::job_t     q_job,
  output logic              out_valid,
  input  logic              out_ready,
  output mav_pkg::res_t     out_res
);
  import mav_pkg::*;

  localparam int HAW = (HEAP_ENTRIES > 1) ? $clog2(HEAP_ENTRIES) : 1;
  localparam int GAW = (GLOBAL_ENTRIES > 1) ? $clog2(GLOBAL_ENTRIES) : 1;
  localparam int HCW = $clog2(HEAP_ENTRIES + 1);
  localparam int GCW = $clog2(GLOBAL_ENTRIES + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_GREAD = 7'b0000010,
    S_GEVAL = 7'b0000100,
    S_HREAD = 7'b0001000,
    S_HEVAL = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  job_t job;
  logic [HCW-1:0] heap_count;
  logic [GCW-1:0] global_count;
  logic [HCW-1:0] hidx;
  logic [GCW-1:0] gidx;
  logic [HEAP_ENTRIES-1:0] freed;
  logic hit, live, found;
  logic [2:0] ev;

  // pending leak held so last can be decided on the next one
  logic        lk_have;
  logic [31:0] lk_addr, lk_size;

  logic hs_we, hz_we, gs_we, gz_we;
  logic [HAW-1:0] h_waddr, h_raddr;
  logic [GAW-1:0] g_waddr, g_raddr;
  logic [31:0] h_wstart, h_wsize, g_wstart, g_wsize;
  logic [31:0] hs_rd, hz_rd, gs_rd, gz_rd;

  mav_ram #(.WIDTH(32), .DEPTH(HEAP_ENTRIES)) u_hs (.clk, .we(hs_we), .waddr(h_waddr),
    .wdata(h_wstart), .raddr(h_raddr), .rdata(hs_rd));
  mav_ram #(.WIDTH(32), .DEPTH(HEAP_ENTRIES)) u_hz (.clk, .we(hz_we), .waddr(h_waddr),
    .wdata(h_wsize), .raddr(h_raddr), .rdata(hz_rd));
  mav_ram #(.WIDTH(32), .DEPTH(GLOBAL_ENTRIES)) u_gs (.clk, .we(gs_we), .waddr(g_waddr),
    .wdata(g_wstart), .raddr(g_raddr), .rdata(gs_rd));
  mav_ram #(.WIDTH(32), .DEPTH(GLOBAL_ENTRIES)) u_gz (.clk, .we(gz_we), .waddr(g_waddr),
    .wdata(g_wsize), .raddr(g_raddr), .rdata(gz_rd));

  logic h_full, g_full, do_reg;
  assign h_full = (heap_count == HCW'(HEAP_ENTRIES));
  assign g_full = (global_count == GCW'(GLOBAL_ENTRIES));
  assign q_ready = (state == S_IDLE);
  assign do_reg = q_valid && q_ready;

  assign h_waddr  = heap_count[HAW-1:0];
  assign g_waddr  = global_count[GAW-1:0];
  assign h_wstart = q_job.cmd.address;
  assign h_wsize  = q_job.cmd.size_bytes;
  assign g_wstart = q_job.cmd.address;
  assign g_wsize  = q_job.cmd.size_bytes;
  assign hs_we = do_reg && (q_job.cmd.kind == K_ALLOC) && !h_full;
  assign hz_we = hs_we;
  assign gs_we = do_reg && (q_job.cmd.kind == K_GLOBAL) && !g_full;
  assign gz_we = gs_we;
  assign h_raddr = hidx[HAW-1:0];
  assign g_raddr = gidx[GAW-1:0];

  // address math on the entry just read
  logic [32:0] a_lo, a_hi, hs_end, gs_end;
  logic h_inside, g_inside, h_over, h_same;
  always_comb begin
    a_lo   = {1'b0, job.cmd.address};
    a_hi   = a_lo + {1'b0, job.cmd.size_bytes};
    hs_end = {1'b0, hs_rd} + {1'b0, hz_rd};
    gs_end = {1'b0, gs_rd} + {1'b0, gz_rd};
    h_inside = ({1'b0, hs_rd} <= a_lo) && (a_hi <= hs_end);
    g_inside = ({1'b0, gs_rd} <= a_lo) && (a_hi <= gs_end);
    h_over   = ({1'b0, hs_rd} < a_hi) && (a_lo < hs_end);
    h_same   = (hs_rd == job.cmd.address);
  end

  logic h_last;
  assign h_last = (hidx == heap_count - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      heap_count   <= '0;
      global_count <= '0;
      out_valid    <= 1'b0;
      lk_have      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            job   <= q_job;
            hidx  <= '0;
            gidx  <= '0;
            hit   <= 1'b0;
            live  <= 1'b0;
            found <= 1'b0;
            lk_have <= 1'b0;
            ev    <= EV_OK;
            case (q_job.cmd.kind)
              K_GLOBAL: begin
                if (g_full) begin
                  ev <= EV_TABLE_FULL;
                end else begin
                  global_count <= global_count + 1'b1;
                end
                state <= S_DONE;
              end
              K_ALLOC: begin
                if (h_full) begin
                  ev <= EV_TABLE_FULL;
                end else begin
                  heap_count <= heap_count + 1'b1;
                  freed[heap_count[HAW-1:0]] <= 1'b0;
                end
                state <= S_DONE;
              end
              K_FREE, K_UAF, K_LEAK: begin
                state <= (heap_count == '0) ? S_DONE : S_HREAD;
              end
              K_READ, K_WRITE: begin
                if (q_job.in_stack) begin
                  found <= 1'b1;
                  state <= S_DONE;
                end else if (global_count != '0) begin
                  state <= S_GREAD;
                end else if (heap_count != '0) begin
                  state <= S_HREAD;
                end else begin
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_GREAD: state <= S_GEVAL;
        S_GEVAL: begin
          if (g_inside) begin
            found <= 1'b1;
            state <= S_DONE;
          end else if (gidx != global_count - 1'b1) begin
            gidx  <= gidx + 1'b1;
            state <= S_GREAD;
          end else begin
            state <= (heap_count != '0) ? S_HREAD : S_DONE;
          end
        end
        S_HREAD: begin
          if (!(job.cmd.kind == K_LEAK && lk_have && out_valid)) begin
            state <= S_HEVAL;
          end
        end
        S_HEVAL: begin
          state <= h_last ? S_DONE : S_HREAD;
          hidx  <= hidx + 1'b1;
          case (job.cmd.kind)
            K_FREE: begin
              if (h_same) begin
                if (freed[hidx[HAW-1:0]]) begin
                  ev <= EV_DOUBLE_FREE;
                end else begin
                  freed[hidx[HAW-1:0]] <= 1'b1;
                  ev <= EV_OK;
                end
                found <= 1'b1;
                state <= S_DONE;
              end
            end
            K_UAF: begin
              if (h_over) begin
                hit <= 1'b1;
                if (!freed[hidx[HAW-1:0]]) begin
                  live <= 1'b1;
                end
              end
            end
            K_LEAK: begin
              if (!freed[hidx[HAW-1:0]]) begin
                if (lk_have) begin
                  out_valid <= 1'b1;
                  out_res   <= '{EV_LEAK, lk_addr, lk_size, 1'b0};
                end
                lk_have <= 1'b1;
                lk_addr <= hs_rd;
                lk_size <= hz_rd;
              end
            end
            default: begin
              if (h_inside) begin
                found <= 1'b1;
                state <= S_DONE;
              end
            end
          endcase
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
            case (job.cmd.kind)
              K_FREE:  out_res <= '{found ? ev : EV_INVALID_FREE, job.cmd.address, 32'd0, 1'b1};
              K_UAF:   out_res <= '{(hit && !live) ? EV_USE_AFTER_FREE : EV_OK,
                                    job.cmd.address, 32'd0, 1'b1};
              K_READ:  out_res <= '{found ? EV_OK : EV_INVALID_READ, job.cmd.address, 32'd0, 1'b1};
              K_WRITE: out_res <= '{found ? EV_OK : EV_INVALID_WRITE,
                                    job.cmd.address, 32'd0, 1'b1};
              K_LEAK: begin
                if (lk_have) begin
                  out_res <= '{EV_LEAK, lk_addr, lk_size, 1'b1};
                end else begin
                  out_res <= '{EV_OK, 32'd0, 32'd0, 1'b1};
                end
              end
              default: out_res <= '{ev, job.cmd.address, 32'd0, 1'b1};
            endcase
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idle_no_out: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !out_valid) else $error("result pending while idle");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    heap_count <= HCW'(HEAP_ENTRIES) && global_count <= GCW'(GLOBAL_ENTRIES))
    else $error("table count overflow");
  a_out_last: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> out_valid && out_res.last) else $error("final beat not flagged");
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
endmodule

// File: design/memory_access_validator.sv
// order: register commands go straight to the result; checks scan the global table (reads and
// writes only) and then the heap table entry by entry before the result is issued
// flow: one command at a time in the back end; each table entry takes a
// memory read state and an evaluate state. the front queue holds two commands.
// reset: synchronous, clears both tables (counts), queue and red zone to 128
module memory_access_validator #(
  parameter int HEAP_ENTRIES   = 64,
  parameter int GLOBAL_ENTRIES = 16
) (
  input logic clk,
  input logic rst,
  mav_cmd_if.sink   cmd,
  mav_res_if.source res,
  mav_cfg_if.sink   cfg
);
  import mav_pkg::*;

  logic [15:0] red_zone;
  logic q_valid, q_ready;
  job_t q_job;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      red_zone <= RED_ZONE_RESET;
    end else if (cfg.valid) begin
      red_zone <= cfg.data;
    end
  end

  mav_front #(.DEPTH(2)) u_front (
    .clk, .rst, .red_zone,
    .in_valid(cmd.valid), .in_ready(cmd.ready), .in_cmd(cmd.data),
    .q_valid, .q_ready, .q_job
  );

  mav_back #(.HEAP_ENTRIES(HEAP_ENTRIES), .GLOBAL_ENTRIES(GLOBAL_ENTRIES)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_job,
    .out_valid(res.valid), .out_ready(res.ready), .out_res(res.data)
  );
endmodule
